// ----- hw/rtl/bark_weighted_spectral_centroid_macros.svh -----
// Assertion macros for the Bark-weighted spectral centroid block
`ifndef BARK_WEIGHTED_SPECTRAL_CENTROID_MACROS_SVH
`define BARK_WEIGHTED_SPECTRAL_CENTROID_MACROS_SVH

// check a condition at every clock edge outside reset
`define BWSC_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// check a consequence in the cycle after its cause
`define BWSC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/bwsc_pkg.sv -----
// Shared types and constants of the Bark-weighted spectral centroid block
package bwsc_pkg;

   localparam int BINS_DEFAULT = 1024;
   localparam int QUEUE_DEPTH  = 2;

   localparam int INDEX_W    = 10;
   localparam int UNIT_W     = 16;
   localparam int WEIGHT_W   = 14;
   localparam int MAG_W      = 12;
   localparam int CENTROID_W = 16;

   localparam int ENTRY_W = UNIT_W + WEIGHT_W;
   localparam int SQ_W    = 2 * MAG_W;
   localparam int PW_W    = SQ_W + WEIGHT_W;
   localparam int PWU_W   = PW_W + UNIT_W;
   localparam int PWS_W   = 48;
   localparam int WUS_W   = 64;

   localparam logic ACT_TABLE = 1'b0;
   localparam logic ACT_BIN   = 1'b1;

   typedef struct packed {
      logic [MAG_W-1:0]    magnitude;
      logic [UNIT_W-1:0]   bark_unit;
      logic [WEIGHT_W-1:0] bark_weight;
      logic                last;
   } bin_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ----- hw/rtl/bwsc_req_if.sv -----
// Request channel: table writes and spectral bins
interface bwsc_req_if;
   logic                           valid;
   logic                           ready;
   logic                           action;
   logic [bwsc_pkg::INDEX_W-1:0]   table_index;
   logic [bwsc_pkg::UNIT_W-1:0]    bark_unit;
   logic [bwsc_pkg::WEIGHT_W-1:0]  bark_weight;
   logic [bwsc_pkg::MAG_W-1:0]     magnitude;
   logic                           last;

   modport source (
      output valid, action, table_index, bark_unit, bark_weight, magnitude, last,
      input  ready
   );
   modport sink (
      input  valid, action, table_index, bark_unit, bark_weight, magnitude, last,
      output ready
   );
endinterface

// ----- hw/rtl/bwsc_rsp_if.sv -----
// Response channel: frame centroid and silent flag
interface bwsc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [bwsc_pkg::CENTROID_W-1:0] centroid;
   logic                            silent;

   modport source (
      output valid, centroid, silent,
      input  ready
   );
   modport sink (
      input  valid, centroid, silent,
      output ready
   );
endinterface

// ----- hw/rtl/bwsc_ram.sv -----
// Generic simple dual-port RAM with registered read
module bwsc_ram #(
   parameter int WIDTH = bwsc_pkg::ENTRY_W,
   parameter int DEPTH = bwsc_pkg::BINS_DEFAULT,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/bwsc_front.sv -----
// Front part: accepts requests, writes the bin table, looks up each bin
module bwsc_front #(
   parameter int BINS = bwsc_pkg::BINS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   bwsc_req_if.sink                   req,
   input  bwsc_pkg::queue_status_type qstat,
   output logic                       push,
   output bwsc_pkg::bin_item_type     push_item
);

   localparam int AW = $clog2(BINS);
   localparam int CW = $clog2(BINS + 1);

   logic                           accept;
   logic                           bin_accept;
   logic                           tbl_write;
   logic                           acc_now;
   logic [CW-1:0]                  cnt_ff;
   logic [CW-1:0]                  cnt_in;
   logic                           s1_valid_ff;
   logic                           s1_valid_in;
   logic [bwsc_pkg::MAG_W-1:0]     s1_mag_ff;
   logic                           s1_last_ff;
   logic                           s1_acc_ff;
   logic [bwsc_pkg::ENTRY_W-1:0]   rd_data;

   assign req.ready  = !s1_valid_ff || !qstat.full;
   assign accept     = req.valid && req.ready;
   assign bin_accept = accept && (req.action == bwsc_pkg::ACT_BIN);
   assign tbl_write  = accept && (req.action == bwsc_pkg::ACT_TABLE)
                       && (32'(req.table_index) < 32'(BINS));
   assign acc_now    = (cnt_ff != '0) && (cnt_ff < CW'(BINS));

   bwsc_ram #(
      .WIDTH (bwsc_pkg::ENTRY_W),
      .DEPTH (BINS)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_write),
      .wr_addr (req.table_index[AW-1:0]),
      .wr_data ({req.bark_unit, req.bark_weight}),
      .rd_en   (bin_accept && acc_now),
      .rd_addr (cnt_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign push = s1_valid_ff && !qstat.full;

   always_comb begin
      push_item.magnitude   = s1_mag_ff;
      push_item.bark_unit   = rd_data[bwsc_pkg::ENTRY_W-1:bwsc_pkg::WEIGHT_W];
      push_item.bark_weight = s1_acc_ff ? rd_data[bwsc_pkg::WEIGHT_W-1:0] : '0;
      push_item.last        = s1_last_ff;
   end

   always_comb begin
      cnt_in      = cnt_ff;
      s1_valid_in = s1_valid_ff;
      if (push) begin
         s1_valid_in = 1'b0;
      end
      if (bin_accept) begin
         s1_valid_in = 1'b1;
         if (req.last) begin
            cnt_in = '0;
         end else if (cnt_ff < CW'(BINS)) begin
            cnt_in = cnt_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         cnt_ff      <= cnt_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (bin_accept) begin
         s1_mag_ff  <= req.magnitude;
         s1_last_ff <= req.last;
         s1_acc_ff  <= acc_now;
      end
   end

endmodule

// ----- hw/rtl/bwsc_queue.sv -----
// Short queue between the front and back parts
module bwsc_queue #(
   parameter int DEPTH = bwsc_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  bwsc_pkg::bin_item_type     push_item,
   input  logic                       pop,
   output bwsc_pkg::bin_item_type     pop_item,
   output bwsc_pkg::queue_status_type status
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   bwsc_pkg::bin_item_type entries_ff [DEPTH];
   logic [PW-1:0]          wr_ptr_ff;
   logic [PW-1:0]          wr_ptr_in;
   logic [PW-1:0]          rd_ptr_ff;
   logic [PW-1:0]          rd_ptr_in;
   logic [NW-1:0]          count_ff;
   logic [NW-1:0]          count_in;

   assign status.full  = (count_ff == NW'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_item     = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + NW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- hw/rtl/bwsc_back.sv -----
// Back part: multiply-accumulate pipeline, centroid divider and response register
module bwsc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  bwsc_pkg::queue_status_type qstat,
   input  bwsc_pkg::bin_item_type     pop_item,
   output logic                       pop,
   bwsc_rsp_if.source                 rsp
);

   localparam int QW = bwsc_pkg::CENTROID_W;
   localparam int SW = $clog2(QW);
   localparam int PS = bwsc_pkg::PWS_W;
   localparam int WS = bwsc_pkg::WUS_W;

   localparam logic [1:0] ST_RUN    = 2'd0;
   localparam logic [1:0] ST_CHECK  = 2'd1;
   localparam logic [1:0] ST_DIVIDE = 2'd2;
   localparam logic [1:0] ST_DONE   = 2'd3;

   logic [1:0]                      state_ff;
   logic [1:0]                      state_in;
   logic                            p1_valid_ff;
   logic                            p2_valid_ff;
   logic                            p3_valid_ff;
   logic                            p1_last_ff;
   logic                            p2_last_ff;
   logic                            p3_last_ff;
   logic [bwsc_pkg::SQ_W-1:0]       p1_sq_ff;
   logic [bwsc_pkg::UNIT_W-1:0]     p1_unit_ff;
   logic [bwsc_pkg::WEIGHT_W-1:0]   p1_weight_ff;
   logic [bwsc_pkg::PW_W-1:0]       p2_pw_ff;
   logic [bwsc_pkg::UNIT_W-1:0]     p2_unit_ff;
   logic [bwsc_pkg::PW_W-1:0]       p3_pw_ff;
   logic [bwsc_pkg::PWU_W-1:0]      p3_pwu_ff;
   logic [PS-1:0]                   pws_ff;
   logic [PS-1:0]                   pws_in;
   logic [WS-1:0]                   wus_ff;
   logic [WS-1:0]                   wus_in;
   logic [PS-1:0]                   rem_ff;
   logic [PS-1:0]                   rem_in;
   logic [QW-1:0]                   low_ff;
   logic [QW-1:0]                   low_in;
   logic [SW-1:0]                   step_ff;
   logic [SW-1:0]                   step_in;
   logic                            silent_res_ff;
   logic                            silent_res_in;
   logic                            out_valid_ff;
   logic                            out_valid_in;
   logic [QW-1:0]                   centroid_ff;
   logic [QW-1:0]                   centroid_in;
   logic                            silent_ff;
   logic                            silent_in;
   logic                            last_in_flight;
   logic [PS:0]                     trial;
   logic [PS:0]                     diff;
   logic                            qbit;

   assign last_in_flight = (p1_valid_ff && p1_last_ff) || (p2_valid_ff && p2_last_ff)
                           || (p3_valid_ff && p3_last_ff);
   assign pop = !qstat.empty && (state_ff == ST_RUN) && !last_in_flight;

   assign rsp.valid    = out_valid_ff;
   assign rsp.centroid = centroid_ff;
   assign rsp.silent   = silent_ff;

   assign trial = {rem_ff, low_ff[QW-1]};
   assign diff  = trial - {1'b0, pws_ff};
   assign qbit  = !diff[PS];

   always_comb begin
      state_in      = state_ff;
      pws_in        = pws_ff;
      wus_in        = wus_ff;
      rem_in        = rem_ff;
      low_in        = low_ff;
      step_in       = step_ff;
      silent_res_in = silent_res_ff;
      out_valid_in  = out_valid_ff && !rsp.ready;
      centroid_in   = centroid_ff;
      silent_in     = silent_ff;
      case (state_ff)
         ST_RUN: begin
            if (p3_valid_ff) begin
               pws_in = pws_ff + PS'(p3_pw_ff);
               wus_in = wus_ff + WS'(p3_pwu_ff);
               if (p3_last_ff) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (pws_ff == '0) begin
               low_in        = '0;
               silent_res_in = 1'b1;
               state_in      = ST_DONE;
            end else if (wus_ff[WS-1:QW] >= pws_ff) begin
               low_in        = '1;
               silent_res_in = 1'b0;
               state_in      = ST_DONE;
            end else begin
               rem_in        = wus_ff[WS-1:QW];
               low_in        = wus_ff[QW-1:0];
               step_in       = SW'(QW - 1);
               silent_res_in = 1'b0;
               state_in      = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            rem_in = qbit ? diff[PS-1:0] : trial[PS-1:0];
            low_in = {low_ff[QW-2:0], qbit};
            if (step_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff - SW'(1);
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp.ready) begin
               out_valid_in = 1'b1;
               centroid_in  = low_ff;
               silent_in    = silent_res_ff;
               pws_in       = '0;
               wus_in       = '0;
               state_in     = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         pws_ff       <= '0;
         wus_ff       <= '0;
         out_valid_ff <= 1'b0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pws_ff       <= pws_in;
         wus_ff       <= wus_in;
         out_valid_ff <= out_valid_in;
         p1_valid_ff  <= pop;
         p2_valid_ff  <= p1_valid_ff;
         p3_valid_ff  <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_sq_ff      <= bwsc_pkg::SQ_W'(pop_item.magnitude)
                       * bwsc_pkg::SQ_W'(pop_item.magnitude);
      p1_unit_ff    <= pop_item.bark_unit;
      p1_weight_ff  <= pop_item.bark_weight;
      p1_last_ff    <= pop_item.last;
      p2_pw_ff      <= bwsc_pkg::PW_W'(p1_sq_ff) * bwsc_pkg::PW_W'(p1_weight_ff);
      p2_unit_ff    <= p1_unit_ff;
      p2_last_ff    <= p1_last_ff;
      p3_pwu_ff     <= bwsc_pkg::PWU_W'(p2_pw_ff) * bwsc_pkg::PWU_W'(p2_unit_ff);
      p3_pw_ff      <= p2_pw_ff;
      p3_last_ff    <= p2_last_ff;
      rem_ff        <= rem_in;
      low_ff        <= low_in;
      step_ff       <= step_in;
      silent_res_ff <= silent_res_in;
      centroid_ff   <= centroid_in;
      silent_ff     <= silent_in;
   end

endmodule

// ----- hw/rtl/bark_weighted_spectral_centroid.sv -----
// Bark-weighted spectral centroid: top level joining front, queue and back parts
//
// Requests are either table writes (action 0), which store the Bark unit and
// Bark weight of one bin, or spectral bins (action 1), one bin per request from
// bin 0 onward; bin 0 is skipped and bins at position BINS or beyond are not
// summed. Requests of either kind are taken one per cycle while the two-entry
// queue has room. Each bin passes through the multiply pipeline (magnitude
// squared, times weight, times unit) before it is summed. The bin marked last
// closes the frame: the back part then drains its pipeline, checks for a zero
// power sum or an overflowing quotient and otherwise runs a 16-step radix-2
// divider; until the response is registered it takes no bin from the queue.
// One response per frame gives the centroid in unsigned Q5.11, saturated at
// 65535, or zero with silent set when the power sum is zero. The bin table has
// no reset; a frame must only use bins whose entries have been written.
module bark_weighted_spectral_centroid #(
   parameter int BINS        = bwsc_pkg::BINS_DEFAULT,
   parameter int QUEUE_DEPTH = bwsc_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   bwsc_req_if.sink   req,
   bwsc_rsp_if.source rsp
);

   logic                       push;
   logic                       pop;
   bwsc_pkg::bin_item_type     push_item;
   bwsc_pkg::bin_item_type     pop_item;
   bwsc_pkg::queue_status_type qstat;

   bwsc_front #(
      .BINS (BINS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .qstat     (qstat),
      .push      (push),
      .push_item (push_item)
   );

   bwsc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .status    (qstat)
   );

   bwsc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .qstat    (qstat),
      .pop_item (pop_item),
      .pop      (pop),
      .rsp      (rsp)
   );

endmodule

// ----- hw/rtl/bwsc_checker.sv -----
// Port-level assertions for the Bark-weighted spectral centroid block
`include "bark_weighted_spectral_centroid_macros.svh"

module bwsc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            req_action,
   input logic                            req_last,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [bwsc_pkg::CENTROID_W-1:0] rsp_centroid,
   input logic                            rsp_silent
);

   logic       frame_end;
   logic       rsp_taken;
   logic [3:0] pending_ff;
   logic [3:0] pending_in;

   assign frame_end = req_valid && req_ready && (req_action == bwsc_pkg::ACT_BIN) && req_last;
   assign rsp_taken = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (frame_end && !rsp_taken) begin
         pending_in = pending_ff + 4'd1;
      end else if (rsp_taken && !frame_end) begin
         pending_in = pending_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `BWSC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
   `BWSC_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_centroid) && $stable(rsp_silent), "response changed while stalled")
   `BWSC_ASSERT_ALWAYS(a_rsp_has_frame, !rsp_valid || (pending_ff != 4'd0), "response without a closed frame")
   `BWSC_ASSERT_ALWAYS(a_silent_zero, !(rsp_valid && rsp_silent) || (rsp_centroid == '0), "silent frame with non-zero centroid")

endmodule

bind bark_weighted_spectral_centroid bwsc_checker u_bwsc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req.valid),
   .req_ready    (req.ready),
   .req_action   (req.action),
   .req_last     (req.last),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_centroid (rsp.centroid),
   .rsp_silent   (rsp.silent)
);
